[hw/rtl/smwm_pkg.sv]
// Shared types and constants for the stack with running median.
// Used by smwm_cell, smwm_chain and stack_with_running_median.
package smwm_pkg;

    localparam int DEPTH       = 1024;
    localparam int VAL_W       = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // Each half keeps room for one extra entry between insert and rebalance.
    localparam int CHAIN_CELLS = DEPTH / 2 + 1;
    localparam int CH_CNT_W    = $clog2(CHAIN_CELLS + 1);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_BAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] x;
    } cmd_t;

    typedef struct packed {
        logic occ;
        logic at_end;
    } cell_ctl_t;

endpackage

[hw/rtl/smwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/smwm_cell.sv]
// One cell of a descending sorted chain: holds one value, shifts with neighbors.
// Depends on smwm_pkg.
module smwm_cell (
    input  logic                         aclk,
    input  smwm_pkg::cmd_t               cmd,
    input  smwm_pkg::cell_ctl_t          ctl,
    input  logic                         prev_ge,
    input  logic [smwm_pkg::VAL_W-1:0]   prev_val,
    input  logic [smwm_pkg::VAL_W-1:0]   next_val,
    output logic [smwm_pkg::VAL_W-1:0]   val,
    output logic                         ge
);

    logic [smwm_pkg::VAL_W-1:0] val_reg;
    logic [smwm_pkg::VAL_W-1:0] val_next;

    assign ge = (val_reg >= cmd.x);

    always_comb begin
        val_next = val_reg;
        case (cmd.op)
            smwm_pkg::OP_INS: begin
                // keep entries at or above x, drop x in the gap, shift the rest down
                if (ctl.occ && ge) begin
                    val_next = val_reg;
                end else if ((ctl.occ || ctl.at_end) && prev_ge) begin
                    val_next = cmd.x;
                end else if (ctl.occ || ctl.at_end) begin
                    val_next = prev_val;
                end
            end
            smwm_pkg::OP_DEL: begin
                // from the first copy of x onward, pull up from the neighbor
                if (ctl.occ && (val_reg <= cmd.x)) begin
                    val_next = next_val;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[hw/rtl/smwm_chain.sv]
// Row of sorted cells kept in descending order; the head cell holds the maximum.
// Depends on smwm_pkg and smwm_cell.
module smwm_chain (
    input  logic                            aclk,
    input  smwm_pkg::cmd_t                  cmd,
    input  logic [smwm_pkg::CH_CNT_W-1:0]   count,
    output logic [smwm_pkg::VAL_W-1:0]      head
);

    logic [smwm_pkg::VAL_W-1:0] val [smwm_pkg::CHAIN_CELLS];
    logic                       ge  [smwm_pkg::CHAIN_CELLS];

    for (genvar i = 0; i < smwm_pkg::CHAIN_CELLS; i++) begin : g_cell
        smwm_pkg::cell_ctl_t        ctl;
        logic                       prev_ge;
        logic [smwm_pkg::VAL_W-1:0] prev_val;
        logic [smwm_pkg::VAL_W-1:0] next_val;

        assign ctl.occ    = (smwm_pkg::CH_CNT_W'(i) < count);
        assign ctl.at_end = (smwm_pkg::CH_CNT_W'(i) == count);

        if (i == 0) begin : g_first
            assign prev_ge  = 1'b1;
            assign prev_val = val[i];
        end else begin : g_mid
            assign prev_ge  = ge[i-1];
            assign prev_val = val[i-1];
        end

        if (i == smwm_pkg::CHAIN_CELLS - 1) begin : g_last
            assign next_val = val[i];
        end else begin : g_inner
            assign next_val = val[i+1];
        end

        smwm_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .ctl      (ctl),
            .prev_ge  (prev_ge),
            .prev_val (prev_val),
            .next_val (next_val),
            .val      (val[i]),
            .ge       (ge[i])
        );
    end

    assign head = val[0];

endmodule

[hw/rtl/stack_with_running_median.sv]
// Stack with running median: stack in a RAM, sorted copy split over two cell chains.
// Peek and error results load the output from the emit state; a pop reads the top
// from the RAM, deletes it from a chain and loads the result with the rebalance step.
// The input stalls over rebalance after a push, delete and rebalance after a pop, and emit
// after a peek or error, none on an ignored action; m_ready holding a result stalls it further.
// Reset clears the entry counts, the control state and the output valid flag;
// the stack RAM, the chain cells and the output status and value are not cleared.
// Depends on smwm_pkg, smwm_ram and smwm_chain.
module stack_with_running_median (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_result_value
);

    smwm_pkg::state_t state_reg, state_next;

    logic [smwm_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [smwm_pkg::CH_CNT_W-1:0] nl_reg, nl_next;
    logic [smwm_pkg::CH_CNT_W-1:0] nu_reg, nu_next;

    logic                       pend_vld_reg, pend_vld_next;
    smwm_pkg::status_t          pend_st_reg, pend_st_next;
    logic [smwm_pkg::VAL_W-1:0] pend_val_reg, pend_val_next;

    logic                       m_valid_reg, m_valid_next;
    smwm_pkg::status_t          m_status_reg, m_status_next;
    logic [smwm_pkg::VAL_W-1:0] m_value_reg, m_value_next;

    smwm_pkg::cmd_t             l_cmd, u_cmd;
    logic [smwm_pkg::VAL_W-1:0] l_head, u_head_raw, u_head;

    logic                        ram_we, ram_re;
    logic [smwm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [smwm_pkg::VAL_W-1:0]  ram_rdata;

    logic accept, out_free, full, empty, load;

    assign s_ready  = (state_reg == smwm_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (cnt_reg == smwm_pkg::CNT_W'(smwm_pkg::DEPTH));
    assign empty    = (cnt_reg == '0);
    // upper half is stored inverted so both chains sort descending
    assign u_head   = ~u_head_raw;

    assign ram_waddr = cnt_reg[smwm_pkg::ADDR_W-1:0];
    assign ram_raddr = smwm_pkg::ADDR_W'(cnt_reg - smwm_pkg::CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smwm_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_action)
                        smwm_pkg::ACT_PUSH: state_next = full ? smwm_pkg::S_EMIT
                                                              : smwm_pkg::S_BAL;
                        smwm_pkg::ACT_POP:  state_next = empty ? smwm_pkg::S_EMIT
                                                               : smwm_pkg::S_DEL;
                        smwm_pkg::ACT_PEEK: state_next = smwm_pkg::S_EMIT;
                        default:            state_next = smwm_pkg::S_IDLE;
                    endcase
                end
            end
            smwm_pkg::S_DEL: begin
                state_next = smwm_pkg::S_BAL;
            end
            smwm_pkg::S_BAL: begin
                state_next = (pend_vld_reg && !out_free) ? smwm_pkg::S_EMIT
                                                         : smwm_pkg::S_IDLE;
            end
            smwm_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = smwm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = smwm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb begin
        cnt_next      = cnt_reg;
        nl_next       = nl_reg;
        nu_next       = nu_reg;
        pend_vld_next = pend_vld_reg;
        pend_st_next  = pend_st_reg;
        pend_val_next = pend_val_reg;
        l_cmd         = '{op: smwm_pkg::OP_NONE, x: '0};
        u_cmd         = '{op: smwm_pkg::OP_NONE, x: '0};
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        load          = 1'b0;
        case (state_reg)
            smwm_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_action)
                        smwm_pkg::ACT_PUSH: begin
                            if (full) begin
                                pend_vld_next = 1'b1;
                                pend_st_next  = smwm_pkg::ST_FULL;
                                pend_val_next = '0;
                            end else begin
                                pend_vld_next = 1'b0;
                                ram_we        = 1'b1;
                                cnt_next      = cnt_reg + smwm_pkg::CNT_W'(1);
                                if (nl_reg == '0 || s_value <= l_head) begin
                                    l_cmd   = '{op: smwm_pkg::OP_INS, x: s_value};
                                    nl_next = nl_reg + smwm_pkg::CH_CNT_W'(1);
                                end else begin
                                    u_cmd   = '{op: smwm_pkg::OP_INS, x: ~s_value};
                                    nu_next = nu_reg + smwm_pkg::CH_CNT_W'(1);
                                end
                            end
                        end
                        smwm_pkg::ACT_POP: begin
                            pend_vld_next = 1'b1;
                            if (empty) begin
                                pend_st_next  = smwm_pkg::ST_EMPTY;
                                pend_val_next = '0;
                            end else begin
                                ram_re   = 1'b1;
                                cnt_next = cnt_reg - smwm_pkg::CNT_W'(1);
                            end
                        end
                        smwm_pkg::ACT_PEEK: begin
                            pend_vld_next = 1'b1;
                            pend_st_next  = empty ? smwm_pkg::ST_EMPTY : smwm_pkg::ST_OK;
                            pend_val_next = empty ? '0 : l_head;
                        end
                        default: begin
                            pend_vld_next = 1'b0;
                        end
                    endcase
                end
            end
            smwm_pkg::S_DEL: begin
                // the popped value sits in the lower half whenever it is at or below its max
                pend_st_next  = smwm_pkg::ST_OK;
                pend_val_next = ram_rdata;
                if (ram_rdata <= l_head) begin
                    l_cmd   = '{op: smwm_pkg::OP_DEL, x: ram_rdata};
                    nl_next = nl_reg - smwm_pkg::CH_CNT_W'(1);
                end else begin
                    u_cmd   = '{op: smwm_pkg::OP_DEL, x: ~ram_rdata};
                    nu_next = nu_reg - smwm_pkg::CH_CNT_W'(1);
                end
            end
            smwm_pkg::S_BAL: begin
                // keep the lower half at ceil(n/2) entries
                if (nl_reg > nu_reg + smwm_pkg::CH_CNT_W'(1)) begin
                    l_cmd   = '{op: smwm_pkg::OP_DEL, x: l_head};
                    u_cmd   = '{op: smwm_pkg::OP_INS, x: ~l_head};
                    nl_next = nl_reg - smwm_pkg::CH_CNT_W'(1);
                    nu_next = nu_reg + smwm_pkg::CH_CNT_W'(1);
                end else if (nu_reg > nl_reg) begin
                    u_cmd   = '{op: smwm_pkg::OP_DEL, x: u_head_raw};
                    l_cmd   = '{op: smwm_pkg::OP_INS, x: u_head};
                    nu_next = nu_reg - smwm_pkg::CH_CNT_W'(1);
                    nl_next = nl_reg + smwm_pkg::CH_CNT_W'(1);
                end
                load = pend_vld_reg && out_free;
            end
            smwm_pkg::S_EMIT: begin
                load = out_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // output register
    always_comb begin
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            m_status_next = pend_st_reg;
            m_value_next  = pend_val_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smwm_pkg::S_IDLE;
            cnt_reg      <= '0;
            nl_reg       <= '0;
            nu_reg       <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            nl_reg       <= nl_next;
            nu_reg       <= nu_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_st_reg  <= pend_st_next;
        pend_val_reg <= pend_val_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
    end

    smwm_ram #(
        .WIDTH (smwm_pkg::VAL_W),
        .DEPTH (smwm_pkg::DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smwm_chain u_lower (
        .aclk  (aclk),
        .cmd   (l_cmd),
        .count (nl_reg),
        .head  (l_head)
    );

    smwm_chain u_upper (
        .aclk  (aclk),
        .cmd   (u_cmd),
        .count (nu_reg),
        .head  (u_head_raw)
    );

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;

endmodule
